// ===== rtl/tld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types, sizes and character codes for the terminal line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

    // pending line store
    localparam int LINE_MAX = 256;
    localparam int LINE_AW  = $clog2(LINE_MAX);
    localparam int LINE_LW  = $clog2(LINE_MAX + 1);

    // read ring
    localparam int RING_SIZE = 1024;
    localparam int RING_AW   = $clog2(RING_SIZE);
    localparam int RING_FW   = $clog2(RING_SIZE + 1);

    // read request limit
    localparam int MAX_READ = 16;
    localparam int READ_W   = 5;
    localparam int RCNT_W   = $clog2(MAX_READ + 1);

    localparam int PID_W  = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CANON = 2'd0;
    localparam logic [IDX_W-1:0] REG_ECHO  = 2'd1;
    localparam logic [IDX_W-1:0] REG_PID   = 2'd2;

    // command codes
    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // character codes
    localparam logic [7:0] CH_INTR  = 8'h03;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_C     = 8'h43;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_INTR  = 2'd2,
        KIND_EMPTY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_COMMIT,
        S_READ
    } t_state;

    typedef struct packed {
        logic             canonical;
        logic             echo;
        logic [PID_W-1:0] pid;
    } t_cfg;

    typedef struct packed {
        logic               we;
        logic [LINE_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [LINE_AW-1:0] raddr;
    } t_line_req;

    typedef struct packed {
        logic               we;
        logic [RING_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [RING_AW-1:0] raddr;
    } t_ring_req;

endpackage
`default_nettype wire

// ===== rtl/tld_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tld_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tld_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/tld_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tld_seq
// Request sequencer: decodes feed and read requests, drives the line store
// and read ring, and registers one result per cycle.
// ----------------------------------------------------------------------------
module tld_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_cmd,
    input  wire logic [7:0]                  i_char_in,
    input  wire logic [tld_pkg::READ_W-1:0]  i_read_max,
    input  wire tld_pkg::t_cfg               i_cfg,
    input  wire logic [7:0]                  i_line_rdata,
    input  wire logic [7:0]                  i_ring_rdata,
    output tld_pkg::t_line_req               o_line_req,
    output tld_pkg::t_ring_req               o_ring_req,
    output logic                             o_busy,
    output logic                             o_result_valid,
    output logic [1:0]                       o_kind,
    output logic [7:0]                       o_data_byte,
    output logic [tld_pkg::PID_W-1:0]        o_target_pid,
    output logic                             o_last
);

    import tld_pkg::*;

    localparam logic [LINE_LW-1:0] LINE_FULL = LINE_LW'(LINE_MAX);
    localparam logic [RING_FW-1:0] RING_FULL = RING_FW'(RING_SIZE);
    localparam logic [READ_W-1:0]  READ_CAP  = READ_W'(MAX_READ);

    t_state             r_state, n_state;
    t_kind              r_q_kind [4];
    t_kind              n_q_kind [4];
    logic [7:0]         r_q_byte [4];
    logic [7:0]         n_q_byte [4];
    logic [2:0]         r_q_cnt, n_q_cnt;
    logic [1:0]         r_q_idx, n_q_idx;
    logic               r_commit, n_commit;
    logic [LINE_LW-1:0] r_line_len, n_line_len;
    logic [LINE_LW-1:0] r_cidx, n_cidx;
    logic               r_cpend, n_cpend;
    logic [RING_AW-1:0] r_oldest, n_oldest;
    logic [RING_FW-1:0] r_fill, n_fill;
    logic [READ_W-1:0]  r_want, n_want;
    logic [RCNT_W-1:0]  r_rcnt, n_rcnt;
    logic               r_pend, n_pend;
    logic               r_pend_last, n_pend_last;
    logic               r_out_valid, n_out_valid;
    t_kind              r_out_kind, n_out_kind;
    logic [7:0]         r_out_byte, n_out_byte;
    logic [PID_W-1:0]   r_out_pid, n_out_pid;
    logic               r_out_last, n_out_last;

    // feed decode
    t_kind              f_kind [4];
    logic [7:0]         f_byte [4];
    logic [2:0]         f_cnt;
    logic               f_commit;
    logic               f_line_we;
    logic               f_push;
    logic [LINE_LW-1:0] f_len;

    logic              acc;
    logic [READ_W-1:0] want;
    logic              emit_last;
    logic              commit_done;
    logic              read_last;

    assign o_busy = (r_state != S_IDLE) || r_pend;
    assign acc    = i_start && !o_busy;
    assign want   = (i_read_max > READ_CAP) ? READ_CAP : i_read_max;
    assign emit_last   = ({1'b0, r_q_idx} + 3'd1) == r_q_cnt;
    assign commit_done = (r_cidx == r_line_len) && !r_cpend;
    assign read_last   = ((READ_W'(r_rcnt) + READ_W'(1)) == r_want)
                      || (r_fill == RING_FW'(1));

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            f_kind[k] = KIND_ECHO;
            f_byte[k] = 8'h00;
        end
        f_cnt     = 3'd0;
        f_commit  = 1'b0;
        f_line_we = 1'b0;
        f_push    = 1'b0;
        f_len     = r_line_len;
        if (i_char_in == CH_INTR) begin
            f_len = '0;
            if (i_cfg.echo) begin
                f_byte[0] = CH_CARET;
                f_byte[1] = CH_C;
                f_byte[2] = CH_NL;
                f_cnt     = 3'd3;
            end
            if (i_cfg.pid != '0) begin
                f_kind[f_cnt[1:0]] = KIND_INTR;
                f_cnt              = f_cnt + 3'd1;
            end
        end else if (!i_cfg.canonical) begin
            f_push = 1'b1;
            if (i_cfg.echo) begin
                f_byte[0] = i_char_in;
                f_cnt     = 3'd1;
            end
        end else if (i_char_in == CH_BS) begin
            if (r_line_len != '0) begin
                f_len = r_line_len - LINE_LW'(1);
                if (i_cfg.echo) begin
                    f_byte[0] = CH_BS;
                    f_byte[1] = CH_SPACE;
                    f_byte[2] = CH_BS;
                    f_cnt     = 3'd3;
                end
            end
        end else begin
            if (r_line_len < LINE_FULL) begin
                f_line_we = 1'b1;
                f_len     = r_line_len + LINE_LW'(1);
            end
            if (i_cfg.echo) begin
                f_byte[0] = i_char_in;
                f_cnt     = 3'd1;
            end
            f_commit = (i_char_in == CH_NL);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_cmd == CMD_READ) begin
                        if ((want != '0) && (r_fill != '0)) begin
                            n_state = S_READ;
                        end
                    end else if (f_cnt != 3'd0) begin
                        n_state = S_EMIT;
                    end else if (f_commit) begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_EMIT: begin
                if (emit_last) begin
                    n_state = r_commit ? S_COMMIT : S_IDLE;
                end
            end
            S_COMMIT: begin
                if (commit_done) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (read_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_q_kind    = r_q_kind;
        n_q_byte    = r_q_byte;
        n_q_cnt     = r_q_cnt;
        n_q_idx     = r_q_idx;
        n_commit    = r_commit;
        n_line_len  = r_line_len;
        n_cidx      = r_cidx;
        n_cpend     = 1'b0;
        n_oldest    = r_oldest;
        n_fill      = r_fill;
        n_want      = r_want;
        n_rcnt      = r_rcnt;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_out_valid = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_pid   = r_out_pid;
        n_out_last  = r_out_last;
        o_line_req  = '0;
        o_ring_req  = '0;

        // popped byte arrives from the ring in the cycle after its read
        if (r_pend) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_DATA;
            n_out_byte  = i_ring_rdata;
            n_out_pid   = '0;
            n_out_last  = r_pend_last;
        end

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_cmd == CMD_READ) begin
                        n_want = want;
                        n_rcnt = '0;
                        if ((want == '0) || (r_fill == '0)) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_EMPTY;
                            n_out_byte  = 8'h00;
                            n_out_pid   = '0;
                            n_out_last  = 1'b1;
                        end
                    end else begin
                        n_q_kind   = f_kind;
                        n_q_byte   = f_byte;
                        n_q_cnt    = f_cnt;
                        n_q_idx    = '0;
                        n_commit   = f_commit;
                        n_cidx     = '0;
                        n_line_len = f_len;
                        o_line_req.we    = f_line_we;
                        o_line_req.waddr = r_line_len[LINE_AW-1:0];
                        o_line_req.wdata = i_char_in;
                        if (f_push && (r_fill < RING_FULL)) begin
                            o_ring_req.we    = 1'b1;
                            o_ring_req.waddr = r_oldest + r_fill[RING_AW-1:0];
                            o_ring_req.wdata = i_char_in;
                            n_fill           = r_fill + RING_FW'(1);
                        end
                    end
                end
            end
            S_EMIT: begin
                n_out_valid = 1'b1;
                n_out_kind  = r_q_kind[r_q_idx];
                n_out_byte  = r_q_byte[r_q_idx];
                n_out_pid   = (r_q_kind[r_q_idx] == KIND_INTR) ? i_cfg.pid : '0;
                n_out_last  = emit_last;
                n_q_idx     = r_q_idx + 2'd1;
            end
            S_COMMIT: begin
                // read one line byte a cycle, push the previous one
                if (r_cidx < r_line_len) begin
                    o_line_req.re    = 1'b1;
                    o_line_req.raddr = r_cidx[LINE_AW-1:0];
                    n_cidx           = r_cidx + LINE_LW'(1);
                    n_cpend          = 1'b1;
                end
                if (r_cpend && (r_fill < RING_FULL)) begin
                    o_ring_req.we    = 1'b1;
                    o_ring_req.waddr = r_oldest + r_fill[RING_AW-1:0];
                    o_ring_req.wdata = i_line_rdata;
                    n_fill           = r_fill + RING_FW'(1);
                end
                if (commit_done) begin
                    n_line_len = '0;
                end
            end
            S_READ: begin
                o_ring_req.re    = 1'b1;
                o_ring_req.raddr = r_oldest;
                n_oldest         = r_oldest + RING_AW'(1);
                n_fill           = r_fill - RING_FW'(1);
                n_rcnt           = r_rcnt + RCNT_W'(1);
                n_pend           = 1'b1;
                n_pend_last      = read_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_line_len  <= '0;
            r_cpend     <= 1'b0;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_line_len  <= n_line_len;
            r_cpend     <= n_cpend;
            r_oldest    <= n_oldest;
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_kind    <= n_q_kind;
        r_q_byte    <= n_q_byte;
        r_q_cnt     <= n_q_cnt;
        r_q_idx     <= n_q_idx;
        r_commit    <= n_commit;
        r_cidx      <= n_cidx;
        r_want      <= n_want;
        r_rcnt      <= n_rcnt;
        r_pend_last <= n_pend_last;
        r_out_kind  <= n_out_kind;
        r_out_byte  <= n_out_byte;
        r_out_pid   <= n_out_pid;
        r_out_last  <= n_out_last;
    end

    assign o_result_valid = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_data_byte    = r_out_byte;
    assign o_target_pid   = r_out_pid;
    assign o_last         = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/tty_line_discipline.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tty_line_discipline
// Canonical/raw terminal line discipline with a line store and a read ring.
// ----------------------------------------------------------------------------
// results: feed results pass S_EMIT and the output register; popped bytes pass
//   S_READ, the ring read register and the output register; one result a cycle
// an empty read result is registered in the cycle after the request is taken
// feed: a newline adds the commit walk; read: one ring read per cycle
// one request at a time; results cannot be stalled by the receiver
// synchronous reset: empty line and ring, canonical mode and echo on, no pid
module tty_line_discipline (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tld_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [tld_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_cmd,
    input  wire logic [7:0]                  i_char_in,
    input  wire logic [tld_pkg::READ_W-1:0]  i_read_max,
    output logic                             o_result_valid,
    output logic [1:0]                       o_kind,
    output logic [7:0]                       o_data_byte,
    output logic [tld_pkg::PID_W-1:0]        o_target_pid,
    output logic                             o_last
);

    import tld_pkg::*;

    t_cfg      r_cfg;
    t_line_req line_req;
    t_ring_req ring_req;
    logic [7:0] line_rdata;
    logic [7:0] ring_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.canonical <= 1'b1;
            r_cfg.echo      <= 1'b1;
            r_cfg.pid       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CANON: r_cfg.canonical <= i_cfg_data[0];
                REG_ECHO:  r_cfg.echo      <= i_cfg_data[0];
                REG_PID:   r_cfg.pid       <= i_cfg_data[PID_W-1:0];
                default: ;
            endcase
        end
    end

    tld_ram #(
        .DEPTH (LINE_MAX),
        .WIDTH (8)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_req.we),
        .i_waddr (line_req.waddr),
        .i_wdata (line_req.wdata),
        .i_re    (line_req.re),
        .i_raddr (line_req.raddr),
        .o_rdata (line_rdata)
    );

    tld_ram #(
        .DEPTH (RING_SIZE),
        .WIDTH (8)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_req.we),
        .i_waddr (ring_req.waddr),
        .i_wdata (ring_req.wdata),
        .i_re    (ring_req.re),
        .i_raddr (ring_req.raddr),
        .o_rdata (ring_rdata)
    );

    tld_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_cmd          (i_cmd),
        .i_char_in      (i_char_in),
        .i_read_max     (i_read_max),
        .i_cfg          (r_cfg),
        .i_line_rdata   (line_rdata),
        .i_ring_rdata   (ring_rdata),
        .o_line_req     (line_req),
        .o_ring_req     (ring_req),
        .o_busy         (busy),
        .o_result_valid (o_result_valid),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_target_pid   (o_target_pid),
        .o_last         (o_last)
    );

    // an interrupt result always names a process
    a_intr_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_kind == KIND_INTR) |-> o_target_pid != '0)
        else $error("interrupt result without target pid");

    // every ring read turns into a data result after the ring read register and the output register
    a_ring_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_req.re |=> ##1 (o_result_valid && (o_kind == KIND_DATA)))
        else $error("ring read without data result");

    // ring is never pushed and popped in the same cycle
    a_ring_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ring_req.we && ring_req.re))
        else $error("ring write and read together");

    // an empty read result ends its request
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_kind == KIND_EMPTY) |-> o_last)
        else $error("empty read result not last");

endmodule
`default_nettype wire

// ===== verif/tty_line_discipline_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tty_line_discipline_test
// Self-checking test of the terminal line discipline: directed checks of
// editing, interrupts, raw mode and a full line, then random typing under
// changing modes, checked against a behavioural model of the discipline.
// ----------------------------------------------------------------------------
module tty_line_discipline_test;
    import tld_pkg::*;

    localparam int SETTLE_CYCLES  = LINE_MAX + 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data;
        logic [PID_W-1:0] pid;
        logic             last;
    } t_tty_out;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic                 i_cmd       = CMD_FEED;
    logic [7:0]           i_char_in   = 8'h00;
    logic [READ_W-1:0]    i_read_max  = '0;
    logic                 o_result_valid;
    logic [1:0]           o_kind;
    logic [7:0]           o_data_byte;
    logic [PID_W-1:0]     o_target_pid;
    logic                 o_last;

    // model of the discipline
    logic                 cfg_canon = 1'b1;
    logic                 cfg_echo  = 1'b1;
    logic [PID_W-1:0]     cfg_pid   = '0;
    logic [7:0]           line_copy [LINE_MAX];
    int unsigned          pend_len     = 0;
    logic [7:0]           ring_copy [RING_SIZE];
    int unsigned          model_oldest = 0;
    int unsigned          model_fill   = 0;

    t_tty_out             due_outputs [$];
    int                   mismatch_count = 0;
    int                   stall_cycles   = 0;
    bit                   steady         = 1'b0;

    tty_line_discipline i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_char_in      (i_char_in),
        .i_read_max     (i_read_max),
        .o_result_valid (o_result_valid),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_target_pid   (o_target_pid),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_tty_out tty_result(input t_kind k, input logic [7:0] b,
                                            input logic [PID_W-1:0] p);
        t_tty_out r;
        r.kind = k;
        r.data = b;
        r.pid  = p;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void model_push(input logic [7:0] b);
        // a full ring drops the byte
        if (model_fill < RING_SIZE) begin
            ring_copy[(model_oldest + model_fill) % RING_SIZE] = b;
            model_fill++;
        end
    endfunction

    function automatic logic [CFG_W-1:0] flag_word(input bit b);
        // upper bits carry noise the block must ignore
        return ($urandom() & 32'hFFFF_FFFE) | b;
    endfunction

    task automatic tty_predict(input logic cmd, input logic [7:0] ch,
                               input logic [READ_W-1:0] rmax);
        t_tty_out    outs [$];
        t_tty_out    r;
        int unsigned want;
        int          k;
        if (cmd == CMD_FEED) begin
            if (ch == CH_INTR) begin
                pend_len = 0;
                if (cfg_echo) begin
                    outs.push_back(tty_result(KIND_ECHO, CH_CARET, '0));
                    outs.push_back(tty_result(KIND_ECHO, CH_C, '0));
                    outs.push_back(tty_result(KIND_ECHO, CH_NL, '0));
                end
                if (cfg_pid != '0)
                    outs.push_back(tty_result(KIND_INTR, 8'h00, cfg_pid));
            end else if (!cfg_canon) begin
                if (cfg_echo) outs.push_back(tty_result(KIND_ECHO, ch, '0));
                model_push(ch);
            end else if (ch == CH_BS) begin
                if (pend_len > 0) begin
                    pend_len--;
                    if (cfg_echo) begin
                        outs.push_back(tty_result(KIND_ECHO, CH_BS, '0));
                        outs.push_back(tty_result(KIND_ECHO, CH_SPACE, '0));
                        outs.push_back(tty_result(KIND_ECHO, CH_BS, '0));
                    end
                end
            end else begin
                // a full line still echoes but stores nothing more
                if (pend_len < LINE_MAX) begin
                    line_copy[pend_len] = ch;
                    pend_len++;
                end
                if (cfg_echo) outs.push_back(tty_result(KIND_ECHO, ch, '0));
                if (ch == CH_NL) begin
                    for (k = 0; k < pend_len; k++) model_push(line_copy[k]);
                    pend_len = 0;
                end
            end
        end else begin
            want = (rmax > MAX_READ) ? MAX_READ : rmax;
            while (outs.size() < want && model_fill > 0) begin
                outs.push_back(tty_result(KIND_DATA, ring_copy[model_oldest], '0));
                model_oldest = (model_oldest + 1) % RING_SIZE;
                model_fill--;
            end
            if (outs.size() == 0) outs.push_back(tty_result(KIND_EMPTY, 8'h00, '0));
        end
        for (k = 0; k < outs.size(); k++) begin
            r = outs[k];
            r.last = (k == outs.size() - 1);
            due_outputs.push_back(r);
        end
    endtask

    // result checker: the block cannot be stalled, so every strobe is a result
    always @(posedge i_clk) begin
        t_tty_out e;
        if (i_rst_n && o_result_valid) begin
            if (due_outputs.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result kind %0d byte %02h pid %08h last %0d",
                         $time, o_kind, o_data_byte, o_target_pid, o_last);
            end else begin
                e = due_outputs.pop_front();
                if (o_kind !== e.kind || o_data_byte !== e.data
                        || o_target_pid !== e.pid || o_last !== e.last) begin
                    mismatch_count++;
                    $display("%0t: expected kind %0d byte %02h pid %08h last %0d",
                             $time, e.kind, e.data, e.pid, e.last);
                    $display("%0t: actual   kind %0d byte %02h pid %08h last %0d",
                             $time, o_kind, o_data_byte, o_target_pid, o_last);
                end
            end
        end
    end

    // watchdog on cycles with neither a request taken nor a result seen
    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_result_valid) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_request(input logic cmd, input logic [7:0] ch,
                                input logic [READ_W-1:0] rmax);
        if (!steady && $urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_char_in  <= ch;
        i_read_max <= rmax;
        do @(posedge i_clk); while (busy);
        tty_predict(cmd, ch, rmax);
    endtask

    task automatic feed_char(input logic [7:0] ch);
        send_request(CMD_FEED, ch, READ_W'($urandom_range(0, 31)));
    endtask

    task automatic read_bytes(input logic [READ_W-1:0] rmax);
        send_request(CMD_READ, 8'($urandom_range(0, 255)), rmax);
    endtask

    task automatic wait_idle(input bit settle);
        start <= 1'b0;
        @(posedge i_clk);
        while (due_outputs.size() != 0) @(posedge i_clk);
        // a commit walk may still be running after the last echo
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        wait_idle(1'b1);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_CANON: cfg_canon = value[0];
            REG_ECHO:  cfg_echo  = value[0];
            REG_PID:   cfg_pid   = value;
            default: ;
        endcase
    endtask

    task automatic drain_ring();
        while (model_fill > 0) read_bytes(READ_W'($urandom_range(1, 31)));
        read_bytes(READ_W'($urandom_range(1, 16)));
    endtask

    task automatic test_canonical_basics();
        feed_char(8'h68);
        feed_char(8'h69);
        feed_char(CH_NL);
        read_bytes('0);
        read_bytes(READ_W'(31));
        read_bytes(READ_W'(MAX_READ));
        feed_char(8'h78);
        feed_char(CH_BS);
        feed_char(CH_BS);
        feed_char(8'hFF);
        feed_char(8'h00);
        feed_char(CH_NL);
        read_bytes(READ_W'(2));
        read_bytes(READ_W'(1));
    endtask

    task automatic test_interrupt();
        set_reg(REG_PID, '0);
        feed_char(8'h61);
        feed_char(CH_INTR);
        set_reg(REG_PID, 32'hFFFF_FFFF);
        feed_char(CH_INTR);
        set_reg(REG_ECHO, flag_word(1'b0));
        feed_char(8'h7A);
        feed_char(CH_INTR);
        feed_char(8'h79);
        feed_char(CH_NL);
        read_bytes(READ_W'(MAX_READ));
        set_reg(REG_ECHO, flag_word(1'b1));
    endtask

    task automatic test_raw_mode();
        set_reg(REG_CANON, flag_word(1'b0));
        feed_char(CH_BS);
        feed_char(CH_NL);
        feed_char(8'h80);
        feed_char(CH_INTR);
        set_reg(REG_UNUSED, $urandom());
        set_reg(REG_ECHO, flag_word(1'b0));
        feed_char(8'h7F);
        read_bytes(READ_W'(31));
    endtask

    task automatic test_line_full();
        int k;
        set_reg(REG_CANON, flag_word(1'b1));
        set_reg(REG_ECHO, flag_word(1'b1));
        feed_char(CH_INTR);
        steady = 1'b1;
        for (k = 0; k < LINE_MAX + 2; k++) feed_char(8'($urandom_range(32, 126)));
        steady = 1'b0;
        feed_char(CH_BS);
        feed_char(8'h51);
        feed_char(8'h52);
        feed_char(CH_NL);
        drain_ring();
    endtask

    task automatic test_random_typing();
        int p;
        int n;
        int pick;
        for (p = 0; p < 8; p++) begin
            set_reg(REG_CANON, flag_word(p % 4 != 2));
            set_reg(REG_ECHO, flag_word(p % 3 != 1));
            case (p % 3)
                0:       set_reg(REG_PID, '0);
                1:       set_reg(REG_PID, 32'hFFFF_FFFF);
                default: set_reg(REG_PID, $urandom());
            endcase
            if (p == 5) set_reg(REG_UNUSED, $urandom());
            steady = (p == 3 || p == 4);
            for (n = 0; n < 24; n++) begin
                pick = $urandom_range(0, 99);
                // mostly printable lines with edits, reads keep the ring moving
                if (pick < 18)      read_bytes(READ_W'($urandom_range(0, 31)));
                else if (pick < 22) feed_char(CH_INTR);
                else if (pick < 32) feed_char(CH_BS);
                else if (pick < 42) feed_char(CH_NL);
                else if (pick < 52) feed_char(8'($urandom_range(0, 255)));
                else                feed_char(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 99) < 4) wait_idle(1'b0);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_canonical_basics();
        test_interrupt();
        test_raw_mode();
        test_line_full();
        test_random_typing();
        wait_idle(1'b1);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
